[hdl/llt_pkg.sv]
// Shared types, constants and helper functions for the learned lookup table core.
`timescale 1ns / 1ps
package llt_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int OUT_IDX_W   = 10;

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [1:0] CMD_PREDICT = 2'd0;
    localparam logic [1:0] CMD_TRAIN   = 2'd1;
    localparam logic [1:0] CMD_BLEND   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_BIAS_OFFSET  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLEND_WEIGHT = 2'd2;

    localparam logic [31:0] BIAS_RESET  = 32'd0;
    localparam logic [30:0] STEP_RESET  = 31'd65536;
    localparam logic [16:0] BLEND_RESET = 17'd65536;
    localparam logic [16:0] BLEND_FULL  = 17'd65536;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EX1,
        ST_EX2,
        ST_EX3,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load_in;
        logic clear_we;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_last;
    } t_dp_status;

    // Clamp a 35-bit signed value into the signed 32-bit range.
    function automatic logic signed [31:0] sat35(input logic signed [34:0] v);
        logic signed [31:0] res;
        if (v[34:31] == 4'b0000 || v[34:31] == 4'b1111) begin
            res = v[31:0];
        end else if (v[34]) begin
            res = 32'sh8000_0000;
        end else begin
            res = 32'sh7FFF_FFFF;
        end
        return res;
    endfunction

endpackage

[hdl/llt_ctrl.sv]
// Controller state machine: clear pass, item sequencing and output handshake.
`timescale 1ns / 1ps
module llt_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  llt_pkg::t_dp_status i_status,
    output llt_pkg::t_dp_cmd    o_cmd
);
    import llt_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clear_we = 1'b1;
                if (i_status.clear_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = ST_READ;
                end
            end
            ST_READ: n_state = ST_EX1;
            ST_EX1:  n_state = ST_EX2;
            ST_EX2:  n_state = ST_EX3;
            ST_EX3:  n_state = ST_DONE;
            ST_DONE: begin
                // hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase

        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

[hdl/llt_dp.sv]
// Datapath: configuration registers, table memory, train and blend arithmetic.
`timescale 1ns / 1ps
module llt_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [llt_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [llt_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic [1:0]                           i_cmd,
    input  logic signed [31:0]                   i_coordinate,
    input  logic signed [31:0]                   i_target,
    input  llt_pkg::t_dp_cmd                     i_ctl,
    output llt_pkg::t_dp_status                  o_status,
    output logic [llt_pkg::OUT_IDX_W-1:0]        o_entry_index,
    output logic signed [31:0]                   o_value
);
    import llt_pkg::*;

    // configuration
    logic [31:0] r_bias;
    logic [30:0] r_step;
    logic [16:0] r_blend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bias  <= BIAS_RESET;
            r_step  <= STEP_RESET;
            r_blend <= BLEND_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_BIAS_OFFSET:  r_bias  <= i_cfg_data[31:0];
                CFG_STEP_SIZE:    r_step  <= i_cfg_data[30:0];
                CFG_BLEND_WEIGHT: r_blend <= i_cfg_data[16:0];
                default: ;
            endcase
        end
    end

    // clear pass counter
    logic [IDX_W-1:0] r_clr_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_ctl.clear_we) begin
            r_clr_cnt <= r_clr_cnt + IDX_W'(1);
        end
    end

    assign o_status.clear_last = (r_clr_cnt == IDX_W'(TABLE_DEPTH - 1));

    // captured item
    logic [IDX_W-1:0]   r_idx;
    logic [1:0]         r_cmd;
    logic signed [31:0] r_target;
    logic [31:0]        idx_sum;

    assign idx_sum = i_coordinate + r_bias;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_in) begin
            r_idx    <= idx_sum[IDX_W-1:0];
            r_cmd    <= i_cmd;
            r_target <= i_target;
        end
    end

    // table memory
    logic [31:0]        r_mem [TABLE_DEPTH];
    logic signed [31:0] r_rdata;
    logic signed [31:0] r_new;
    logic [IDX_W-1:0]   wr_addr;
    logic [31:0]        wr_data;
    logic               wr_en;

    assign wr_en   = i_ctl.clear_we | i_ctl.commit;
    assign wr_addr = i_ctl.clear_we ? r_clr_cnt : r_idx;
    assign wr_data = i_ctl.clear_we ? 32'd0 : r_new;

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[r_idx];
    end

    // stage 1: differences, step candidates and blend products
    logic signed [33:0] cur34, tgt34, stp34;
    logic signed [33:0] r_s1_diff, r_s1_up, r_s1_dn;
    logic [16:0]        blend_w, blend_keep;
    logic signed [49:0] r_prod_keep, r_prod_w;

    assign cur34      = {{2{r_rdata[31]}}, r_rdata};
    assign tgt34      = {{2{r_target[31]}}, r_target};
    assign stp34      = {3'b000, r_step};
    assign blend_w    = (r_blend > BLEND_FULL) ? BLEND_FULL : r_blend;
    assign blend_keep = BLEND_FULL - blend_w;

    always_ff @(posedge i_clk) begin
        r_s1_diff   <= cur34 - tgt34;
        r_s1_up     <= cur34 + stp34;
        r_s1_dn     <= cur34 - stp34;
        r_prod_keep <= $signed({1'b0, blend_keep}) * r_rdata;
        r_prod_w    <= $signed({1'b0, blend_w}) * r_target;
    end

    // stage 2: absolute errors and blend sum
    logic signed [34:0] diff35, stp35, du, dd;
    logic [34:0]        r_e0, r_eu, r_ed;
    logic signed [50:0] r_sum;

    assign diff35 = {r_s1_diff[33], r_s1_diff};
    assign stp35  = {4'b0000, r_step};
    assign du     = diff35 + stp35;
    assign dd     = diff35 - stp35;

    always_ff @(posedge i_clk) begin
        r_e0  <= diff35[34] ? 35'(-diff35) : 35'(diff35);
        r_eu  <= du[34] ? 35'(-du) : 35'(du);
        r_ed  <= dd[34] ? 35'(-dd) : 35'(dd);
        r_sum <= {r_prod_keep[49], r_prod_keep} + {r_prod_w[49], r_prod_w};
    end

    // stage 3: pick the move and saturate
    logic               take_up, take_dn;
    logic signed [31:0] train_val, blend_val, n_new;

    assign take_up = (r_eu < r_e0) && (r_eu <= r_ed);
    assign take_dn = (r_ed < r_e0);

    always_comb begin
        if (take_up) begin
            train_val = sat35({r_s1_up[33], r_s1_up});
        end else if (take_dn) begin
            train_val = sat35({r_s1_dn[33], r_s1_dn});
        end else begin
            train_val = r_rdata;
        end
        // arithmetic shift floors toward minus infinity
        blend_val = sat35(r_sum[50:16]);
        unique case (r_cmd)
            CMD_TRAIN: n_new = train_val;
            CMD_BLEND: n_new = blend_val;
            default:   n_new = r_rdata;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_new <= n_new;
    end

    // output register
    logic [IDX_W+OUT_IDX_W-1:0] idx_wide;
    logic [OUT_IDX_W-1:0]       r_out_idx;
    logic signed [31:0]         r_out_value;

    assign idx_wide = {{OUT_IDX_W{1'b0}}, r_idx};

    always_ff @(posedge i_clk) begin
        if (i_ctl.commit) begin
            r_out_idx   <= idx_wide[OUT_IDX_W-1:0];
            r_out_value <= r_new;
        end
    end

    assign o_entry_index = r_out_idx;
    assign o_value       = r_out_value;

endmodule

[hdl/learned_lookup_table_step_train_core.sv]
// Top level of the learned lookup table core: controller, datapath and checks.
`timescale 1ns / 1ps
// Each transaction runs READ, EX1, EX2, EX3 and DONE (read, three arithmetic
// stages, write-back) and is registered onto o_out_valid at write-back; DONE
// waits for a free output, and no new transaction is accepted until then.
// Reset: synchronous active-low; afterwards a clearing pass zeroes all
// TABLE_DEPTH entries, one per cycle, before o_in_ready rises.
module learned_lookup_table_step_train_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write port
    input  logic                             i_cfg_we,
    input  logic [llt_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [llt_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // input channel
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [1:0]                       i_cmd,
    input  logic signed [31:0]               i_coordinate,
    input  logic signed [31:0]               i_target,
    // output channel
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [llt_pkg::OUT_IDX_W-1:0]    o_entry_index,
    output logic signed [31:0]               o_value
);
    import llt_pkg::*;

    // Commands flow from the controller to the datapath; the datapath only
    // reports the end of the clearing pass back.
    t_dp_cmd    s_cmd;
    t_dp_status s_status;

    // Sequence each transaction: accept, read the entry, run the three
    // arithmetic stages, then write back and load the output register in
    // the same cycle.
    llt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (s_status),
        .o_cmd       (s_cmd)
    );

    // Hold configuration, the table memory and the train / blend arithmetic.
    llt_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_cmd         (i_cmd),
        .i_coordinate  (i_coordinate),
        .i_target      (i_target),
        .i_ctl         (s_cmd),
        .o_status      (s_status),
        .o_entry_index (o_entry_index),
        .o_value       (o_value)
    );

    // Commit only when the output register is free, or a result is lost.
    a_commit_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.commit |-> (!o_out_valid || i_out_ready))
        else $error("result committed over a pending output");

    // A committed result is presented in the next cycle.
    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.commit |=> o_out_valid)
        else $error("committed result not presented");

    // No transaction is taken while the clearing pass runs.
    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.clear_we |-> !o_in_ready)
        else $error("input ready during clearing pass");

    // An accepted transaction has o_out_valid high after its READ, EX1, EX2, EX3 and DONE states.
    a_result_arrives: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> ##5 o_out_valid)
        else $error("no result after accepted transaction");

endmodule
